[hdl/tmcw_pkg.sv]
// Shared types and constants for the text mode console writer.
`default_nettype none

package tmcw_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [2:0] OP_PUT_CHAR     = 3'd0;
    localparam logic [2:0] OP_NEWLINE      = 3'd1;
    localparam logic [2:0] OP_CLEAR_SCREEN = 3'd2;
    localparam logic [2:0] OP_CLEAR_ROW    = 3'd3;
    localparam logic [2:0] OP_CLEAR_EOL    = 3'd4;
    localparam logic [2:0] OP_SET_CURSOR   = 3'd5;
    localparam logic [2:0] OP_SET_BG       = 3'd6;
    localparam logic [2:0] OP_READ_CELL    = 3'd7;

    // Kinds of sweep over the cell memory.
    localparam logic [2:0] SW_FILL_BOOT = 3'd0;
    localparam logic [2:0] SW_FILL_ALL  = 3'd1;
    localparam logic [2:0] SW_FILL_ROW  = 3'd2;
    localparam logic [2:0] SW_FILL_EOL  = 3'd3;
    localparam logic [2:0] SW_FILL_LAST = 3'd4;
    localparam logic [2:0] SW_COPY      = 3'd5;
    localparam logic [2:0] SW_BG        = 3'd6;

    // Cursor updates.
    localparam logic [2:0] CUR_HOLD     = 3'd0;
    localparam logic [2:0] CUR_INC      = 3'd1;
    localparam logic [2:0] CUR_NEWLINE  = 3'd2;
    localparam logic [2:0] CUR_LAST_ROW = 3'd3;
    localparam logic [2:0] CUR_HOME     = 3'd4;
    localparam logic [2:0] CUR_SET      = 3'd5;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_ATTR   = 8'h07;
    localparam logic [7:0] BG_MASK      = 8'hF0;
    localparam logic [7:0] FG_MASK      = 8'h0F;

    localparam int CELL_W = 16;

    typedef struct packed {
        logic       latch_in;
        logic       sweep_start;
        logic [2:0] sweep_kind;
        logic [2:0] cur_op;
        logic       write_char;
        logic       read_cell;
        logic       capture_read;
        logic       set_err;
        logic       load_out;
    } tmcw_cmd_t;

    typedef struct packed {
        logic       sweep_busy;
        logic       past_end;
        logic       on_last_row;
        logic       row_ok;
        logic       nl_char;
        logic [2:0] op;
    } tmcw_stat_t;

endpackage

`default_nettype wire

[hdl/tmcw_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/tmcw_dp.sv]
// Datapath: cell memory, cursor, sweep engine, input and result registers.
`default_nettype none

module tmcw_dp import tmcw_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    input  wire logic [7:0] cfg_data,
    input  wire logic [31:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire tmcw_cmd_t   cmd,
    output tmcw_stat_t       stat,
    output logic [39:0]      m_tdata,
    output logic             m_tuser
);

    localparam int NCELLS = ROWS * COLS;
    localparam int IW = $clog2(NCELLS + 1);
    localparam int AW = $clog2(NCELLS);
    localparam int CW = $clog2(COLS);
    localparam int RW = $clog2(ROWS + 1);

    localparam logic [IW-1:0] COLS_I     = IW'(COLS);
    localparam logic [IW-1:0] N_LAST     = IW'(NCELLS - 1);
    localparam logic [IW-1:0] LAST_ROW_I = IW'(NCELLS - COLS);
    localparam logic [IW-1:0] COPY_LAST  = IW'(NCELLS - COLS - 1);
    localparam logic [CW-1:0] COL_MAX    = CW'(COLS - 1);
    localparam logic [RW-1:0] ROW_MAX    = RW'(ROWS - 1);
    localparam logic [RW-1:0] ROWS_R     = RW'(ROWS);

    logic [7:0] default_attr_reg;

    logic [2:0] op_reg;
    logic [7:0] char_reg, attr_reg, col_reg, row_reg;

    logic [IW-1:0] cur_idx_reg, cur_idx_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;

    logic [CW-1:0] col_c;
    logic [RW-1:0] row_c;
    logic          row_ok;
    logic [IW-1:0] row_base, cell_idx;

    logic [2:0]    sw_kind_reg;
    logic [IW-1:0] sw_addr_reg, sw_addr_next;
    logic [IW-1:0] sw_last_reg, sw_last_next;
    logic [IW-1:0] sw_first;
    logic          sw_issue_reg, sw_issue_next;
    logic          wr_pend_reg;
    logic [AW-1:0] wr_addr_reg;
    logic          sw_is_fill, sw_is_copy;
    logic [7:0]    fill_attr;
    logic [IW-1:0] sw_rd_addr;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    logic       err_reg;
    logic [7:0] rchar_reg, rattr_reg;

    logic [31:0] idx_w, col_w, row_w;
    logic [10:0] out_idx_reg;
    logic [6:0]  out_col_reg;
    logic [4:0]  out_row_reg;
    logic [7:0]  out_rchar_reg, out_rattr_reg;
    logic        out_err_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= RESET_ATTR;
        end
        else if (cfg_valid)
        begin
            default_attr_reg <= cfg_data;
        end
    end

    // Input word.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg   <= s_tuser;
            char_reg <= s_tdata[7:0];
            attr_reg <= s_tdata[15:8];
            col_reg  <= s_tdata[23:16];
            row_reg  <= s_tdata[31:24];
        end
    end

    // Clamp the signed column and row into the screen.
    always_comb
    begin
        if (col_reg[7])
        begin
            col_c = '0;
        end
        else if (int'(col_reg[6:0]) >= COLS)
        begin
            col_c = COL_MAX;
        end
        else
        begin
            col_c = CW'(col_reg[6:0]);
        end

        row_ok = !row_reg[7] && (int'(row_reg[6:0]) < ROWS);
        if (row_reg[7])
        begin
            row_c = '0;
        end
        else if (!row_ok)
        begin
            row_c = ROW_MAX;
        end
        else
        begin
            row_c = RW'(row_reg[6:0]);
        end
    end

    assign row_base = IW'(int'(row_c) * COLS);
    assign cell_idx = row_base + IW'(col_c);

    // Cursor.
    always_comb
    begin
        cur_idx_next = cur_idx_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        case (cmd.cur_op)
            CUR_INC:
            begin
                cur_idx_next = cur_idx_reg + IW'(1);
                if (cur_col_reg == COL_MAX)
                begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + RW'(1);
                end
                else
                begin
                    cur_col_next = cur_col_reg + CW'(1);
                end
            end
            CUR_NEWLINE:
            begin
                cur_idx_next = cur_idx_reg - IW'(cur_col_reg) + COLS_I;
                cur_col_next = '0;
                cur_row_next = cur_row_reg + RW'(1);
            end
            CUR_LAST_ROW:
            begin
                cur_idx_next = LAST_ROW_I;
                cur_col_next = '0;
                cur_row_next = ROW_MAX;
            end
            CUR_HOME:
            begin
                cur_idx_next = '0;
                cur_col_next = '0;
                cur_row_next = '0;
            end
            CUR_SET:
            begin
                cur_idx_next = cell_idx;
                cur_col_next = col_c;
                cur_row_next = row_c;
            end
            default:
            begin
                cur_idx_next = cur_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_idx_reg <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end
        else
        begin
            cur_idx_reg <= cur_idx_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    // Sweep engine: fills write one cell a cycle; copy and background
    // updates read a cell and write a cell in the next cycle, a copy one row above the cell it read.
    always_comb
    begin
        case (cmd.sweep_kind)
            SW_FILL_ROW:
            begin
                sw_first     = row_base;
                sw_last_next = row_base + COLS_I - IW'(1);
            end
            SW_FILL_EOL:
            begin
                sw_first     = cur_idx_reg;
                sw_last_next = cur_idx_reg - IW'(cur_col_reg) + COLS_I - IW'(1);
            end
            SW_FILL_LAST:
            begin
                sw_first     = LAST_ROW_I;
                sw_last_next = N_LAST;
            end
            SW_COPY:
            begin
                sw_first     = '0;
                sw_last_next = COPY_LAST;
            end
            default:
            begin
                sw_first     = '0;
                sw_last_next = N_LAST;
            end
        endcase

        sw_issue_next = sw_issue_reg;
        sw_addr_next  = sw_addr_reg;
        if (cmd.sweep_start)
        begin
            sw_issue_next = 1'b1;
            sw_addr_next  = sw_first;
        end
        else if (sw_issue_reg)
        begin
            if (sw_addr_reg == sw_last_reg)
            begin
                sw_issue_next = 1'b0;
            end
            else
            begin
                sw_addr_next = sw_addr_reg + IW'(1);
            end
        end
    end

    assign sw_is_copy = (sw_kind_reg == SW_COPY);
    assign sw_is_fill = !sw_is_copy && (sw_kind_reg != SW_BG);
    assign fill_attr  = (sw_kind_reg == SW_FILL_BOOT) ? RESET_ATTR : default_attr_reg;
    assign sw_rd_addr = sw_addr_reg + (sw_is_copy ? COLS_I : IW'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_issue_reg <= 1'b0;
            wr_pend_reg  <= 1'b0;
        end
        else
        begin
            sw_issue_reg <= sw_issue_next;
            wr_pend_reg  <= sw_issue_reg && !sw_is_fill;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_addr_reg <= sw_addr_next;
        wr_addr_reg <= sw_addr_reg[AW-1:0];
        if (cmd.sweep_start)
        begin
            sw_kind_reg <= cmd.sweep_kind;
            sw_last_reg <= sw_last_next;
        end
    end

    // Memory port selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_idx_reg[AW-1:0];
        ram_wdata = {attr_reg, char_reg};
        if (sw_issue_reg && sw_is_fill)
        begin
            ram_we    = 1'b1;
            ram_waddr = sw_addr_reg[AW-1:0];
            ram_wdata = {fill_attr, BLANK_CHAR};
        end
        else if (wr_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = wr_addr_reg;
            if (sw_is_copy)
            begin
                ram_wdata = ram_rdata;
            end
            else
            begin
                ram_wdata = {(ram_rdata[15:8] & FG_MASK) | (attr_reg & BG_MASK),
                             ram_rdata[7:0]};
            end
        end
        else if (cmd.write_char)
        begin
            ram_we = 1'b1;
        end

        ram_re    = cmd.read_cell;
        ram_raddr = cell_idx[AW-1:0];
        if (sw_issue_reg && !sw_is_fill)
        begin
            ram_re    = 1'b1;
            ram_raddr = sw_rd_addr[AW-1:0];
        end
    end

    tmcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Result of the current command.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            err_reg   <= 1'b0;
            rchar_reg <= '0;
            rattr_reg <= '0;
        end
        else
        begin
            if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.capture_read)
            begin
                rchar_reg <= ram_rdata[7:0];
                rattr_reg <= ram_rdata[15:8];
            end
        end
    end

    assign idx_w = 32'(cur_idx_reg);
    assign col_w = 32'(cur_col_reg);
    assign row_w = 32'(cur_row_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_idx_reg   <= idx_w[10:0];
            out_col_reg   <= col_w[6:0];
            out_row_reg   <= row_w[4:0];
            out_rchar_reg <= rchar_reg;
            out_rattr_reg <= rattr_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign m_tdata = {1'b0, out_rattr_reg, out_rchar_reg, out_row_reg, out_col_reg, out_idx_reg};
    assign m_tuser = out_err_reg;

    assign stat.sweep_busy  = sw_issue_reg || wr_pend_reg;
    assign stat.past_end    = (cur_row_reg == ROWS_R);
    assign stat.on_last_row = (cur_row_reg >= ROW_MAX);
    assign stat.row_ok      = row_ok;
    assign stat.nl_char     = (char_reg == NEWLINE_CHAR);
    assign stat.op          = op_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_col_reg <= COL_MAX) && (cur_row_reg <= ROWS_R)
        && ((cur_row_reg != ROWS_R) || (cur_col_reg == '0)))
        else $error("cursor column or row out of range");

    a_sweep_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        sw_issue_reg |-> (sw_addr_reg <= sw_last_reg))
        else $error("sweep address passed its last cell");

endmodule

`default_nettype wire

[hdl/tmcw_ctrl.sv]
// Controller: sequences each command over the datapath and owns the handshakes.
`default_nettype none

module tmcw_ctrl import tmcw_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire tmcw_stat_t stat,
    output tmcw_cmd_t       cmd
);

    localparam logic [3:0] ST_BOOT        = 4'd0;
    localparam logic [3:0] ST_BOOT_WAIT   = 4'd1;
    localparam logic [3:0] ST_IDLE        = 4'd2;
    localparam logic [3:0] ST_EXEC        = 4'd3;
    localparam logic [3:0] ST_FILL_WAIT   = 4'd4;
    localparam logic [3:0] ST_SCROLL_COPY = 4'd5;
    localparam logic [3:0] ST_SCROLL_FILL = 4'd6;
    localparam logic [3:0] ST_PUT         = 4'd7;
    localparam logic [3:0] ST_READ        = 4'd8;
    localparam logic [3:0] ST_DONE        = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       text_char;

    assign text_char = (stat.op == OP_PUT_CHAR) && !stat.nl_char;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_BOOT:
            begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_kind  = SW_FILL_BOOT;
                state_next      = ST_BOOT_WAIT;
            end
            ST_BOOT_WAIT:
            begin
                if (!stat.sweep_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (stat.op)
                    OP_PUT_CHAR, OP_NEWLINE:
                    begin
                        if (text_char)
                        begin
                            if (stat.past_end)
                            begin
                                cmd.sweep_start = 1'b1;
                                cmd.sweep_kind  = SW_COPY;
                                state_next      = ST_SCROLL_COPY;
                            end
                            else
                            begin
                                cmd.write_char = 1'b1;
                                cmd.cur_op     = CUR_INC;
                            end
                        end
                        else if (stat.on_last_row)
                        begin
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_kind  = SW_COPY;
                            state_next      = ST_SCROLL_COPY;
                        end
                        else
                        begin
                            cmd.cur_op = CUR_NEWLINE;
                        end
                    end
                    OP_CLEAR_SCREEN:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_kind  = SW_FILL_ALL;
                        cmd.cur_op      = CUR_HOME;
                        state_next      = ST_FILL_WAIT;
                    end
                    OP_CLEAR_ROW:
                    begin
                        if (stat.row_ok)
                        begin
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_kind  = SW_FILL_ROW;
                            state_next      = ST_FILL_WAIT;
                        end
                        else
                        begin
                            cmd.set_err = 1'b1;
                        end
                    end
                    OP_CLEAR_EOL:
                    begin
                        if (stat.past_end)
                        begin
                            cmd.set_err = 1'b1;
                        end
                        else
                        begin
                            cmd.sweep_start = 1'b1;
                            cmd.sweep_kind  = SW_FILL_EOL;
                            state_next      = ST_FILL_WAIT;
                        end
                    end
                    OP_SET_CURSOR:
                    begin
                        cmd.cur_op = CUR_SET;
                    end
                    OP_SET_BG:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_kind  = SW_BG;
                        state_next      = ST_FILL_WAIT;
                    end
                    default:
                    begin
                        cmd.read_cell = 1'b1;
                        state_next    = ST_READ;
                    end
                endcase
            end
            ST_FILL_WAIT:
            begin
                if (!stat.sweep_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL_COPY:
            begin
                // Rows have moved up; blank the new bottom row.
                if (!stat.sweep_busy)
                begin
                    cmd.sweep_start = 1'b1;
                    cmd.sweep_kind  = SW_FILL_LAST;
                    cmd.cur_op      = CUR_LAST_ROW;
                    state_next      = ST_SCROLL_FILL;
                end
            end
            ST_SCROLL_FILL:
            begin
                if (!stat.sweep_busy)
                begin
                    state_next = text_char ? ST_PUT : ST_DONE;
                end
            end
            ST_PUT:
            begin
                cmd.write_char = 1'b1;
                cmd.cur_op     = CUR_INC;
                state_next     = ST_DONE;
            end
            ST_READ:
            begin
                cmd.capture_read = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_BOOT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_start |-> !stat.sweep_busy)
        else $error("sweep started while another sweep is running");

    a_char_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_char |-> !stat.sweep_busy)
        else $error("character write collides with a sweep");

    a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !stat.sweep_busy)
        else $error("word accepted while the memory is busy");

    a_load_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid)
        else $error("result loaded but not offered");

endmodule

`default_nettype wire

[hdl/text_mode_console_writer_top.sv]
// Clear screen, set background and a scroll each sweep over every cell, clear row and clear to
// end of line over at most one row, all through the single write port of the cell memory.
// One command is in work at a time; the next word is taken as its result is offered, so a
// result left waiting holds the input. After reset the cells are cleared to reset-attribute blanks.
`default_nettype none

module text_mode_console_writer_top import tmcw_pkg::*; #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,   // default_attr
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // char_code, attr_value, col, row
    input  wire logic [2:0]  s_tuser,    // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,    // cursor_index, cursor_col, cursor_row,
                                         // read_char, read_attr, zero pad
    output logic             m_tuser     // error_flag
);

    tmcw_cmd_t  cmd;
    tmcw_stat_t stat;

    assign cfg_ready = 1'b1;

    tmcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tmcw_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[verif/text_mode_console_writer_top_tb.sv]
// Self-checking testbench for the text mode console writer, with a cell-accurate scoreboard.
`timescale 1ns / 100ps

module text_mode_console_writer_top_tb;
    import tmcw_pkg::*;

    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 16;
    localparam int PHASE_WORDS  = 220;

    typedef struct packed {
        logic       err;
        logic [7:0] rattr;
        logic [7:0] rchar;
        logic [4:0] crow;
        logic [6:0] ccol;
        logic [10:0] cidx;
    } console_status_t;

    // Shadow copy of the screen and cursor; predicts the status word of every command.
    class console_scoreboard;
        logic [15:0]     cells [SCREEN_CELLS];
        int unsigned     cursor;
        logic [7:0]      blank_attr;
        console_status_t expected_status [$];
        int              mismatch_count;
        string           field_names [6];

        function new();
            blank_attr = RESET_ATTR;
            cursor = 0;
            mismatch_count = 0;
            blank_range(0, SCREEN_CELLS);
            field_names = '{"cursor_index", "cursor_col", "cursor_row",
                            "read_char", "read_attr", "error_flag"};
        endfunction

        function void set_blank_attr(logic [7:0] value);
            blank_attr = value;
        endfunction

        function int pending_count();
            return expected_status.size();
        endfunction

        function void blank_range(int unsigned first, int unsigned last);
            for (int unsigned i = first; i < last && i < SCREEN_CELLS; i++)
                cells[i] = {blank_attr, BLANK_CHAR};
        endfunction

        function void scroll_screen();
            for (int unsigned i = 0; i + SCREEN_COLS < SCREEN_CELLS; i++)
                cells[i] = cells[i + SCREEN_COLS];
            blank_range(SCREEN_CELLS - SCREEN_COLS, SCREEN_CELLS);
            cursor = (cursor >= SCREEN_COLS) ? cursor - SCREEN_COLS : 0;
        endfunction

        function void line_feed();
            int unsigned y;
            y = cursor / SCREEN_COLS;
            if (y + 1 >= SCREEN_ROWS)
            begin
                scroll_screen();
                cursor = (SCREEN_ROWS - 1) * SCREEN_COLS;
            end
            else
                cursor = (y + 1) * SCREEN_COLS;
        endfunction

        function int unsigned clamp(int v, int lim);
            if (v < 0)
                return 0;
            if (v >= lim)
                return lim - 1;
            return v;
        endfunction

        function void note_command(logic [2:0] op, logic [7:0] ch, logic [7:0] attr,
                                   logic signed [7:0] col, logic signed [7:0] row);
            console_status_t res;
            int              cv;
            int              rv;
            int unsigned     idx;
            res = '0;
            cv = int'(col);
            rv = int'(row);
            case (op)
                OP_PUT_CHAR:
                    if (ch == NEWLINE_CHAR)
                        line_feed();
                    else
                    begin
                        if (cursor >= SCREEN_CELLS)
                            scroll_screen();
                        if (cursor < SCREEN_CELLS)
                        begin
                            cells[cursor] = {attr, ch};
                            cursor++;
                        end
                    end
                OP_NEWLINE:
                    line_feed();
                OP_CLEAR_SCREEN:
                begin
                    blank_range(0, SCREEN_CELLS);
                    cursor = 0;
                end
                OP_CLEAR_ROW:
                    if (rv < 0 || rv >= SCREEN_ROWS)
                        res.err = 1'b1;
                    else
                        blank_range(rv * SCREEN_COLS, (rv + 1) * SCREEN_COLS);
                OP_CLEAR_EOL:
                    if (cursor >= SCREEN_CELLS)
                        res.err = 1'b1;
                    else
                        blank_range(cursor, (cursor / SCREEN_COLS + 1) * SCREEN_COLS);
                OP_SET_CURSOR:
                    cursor = clamp(rv, SCREEN_ROWS) * SCREEN_COLS + clamp(cv, SCREEN_COLS);
                OP_SET_BG:
                    for (int i = 0; i < SCREEN_CELLS; i++)
                        cells[i][15:8] = (cells[i][15:8] & FG_MASK) | (attr & BG_MASK);
                OP_READ_CELL:
                begin
                    idx = clamp(rv, SCREEN_ROWS) * SCREEN_COLS + clamp(cv, SCREEN_COLS);
                    res.rchar = cells[idx][7:0];
                    res.rattr = cells[idx][15:8];
                end
            endcase
            res.cidx = 11'(cursor);
            res.ccol = 7'(cursor % SCREEN_COLS);
            res.crow = 5'(cursor / SCREEN_COLS);
            expected_status.push_back(res);
        endfunction

        function void check_result(logic [39:0] data, logic err_flag);
            console_status_t exp;
            int              exp_f [6];
            int              got_f [6];
            if (expected_status.size() == 0)
            begin
                $display("%0t: status word with nothing expected, got cursor %0d error %0d",
                         $time, data[10:0], err_flag);
                mismatch_count++;
                return;
            end
            exp = expected_status.pop_front();
            exp_f = '{int'(exp.cidx), int'(exp.ccol), int'(exp.crow), int'(exp.rchar),
                      int'(exp.rattr), int'(exp.err)};
            got_f = '{int'(data[10:0]), int'(data[17:11]), int'(data[22:18]),
                      int'(data[30:23]), int'(data[38:31]), int'(err_flag)};
            for (int i = 0; i < 6; i++)
                if (exp_f[i] != got_f[i])
                begin
                    $display("%0t: %s expected %0d, got %0d", $time, field_names[i],
                             exp_f[i], got_f[i]);
                    mismatch_count++;
                end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    console_scoreboard sb = new();
    bit                long_hold_req = 1'b0;
    int                words_sent = 0;
    int                idle_cycles = 0;

    text_mode_console_writer_top #(
        .COLS (SCREEN_COLS),
        .ROWS (SCREEN_ROWS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Ends the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly on screen, sometimes right at or beyond an edge, sometimes anything at all.
    function automatic logic [7:0] pick_coord(int lim);
        int r;
        int edges [6];
        edges = '{-1, lim, -128, 127, 0, lim - 1};
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(0, lim - 1));
        if (r < 85)
            return 8'(edges[$urandom_range(0, 5)]);
        return rnd8();
    endfunction

    task automatic send_command(input logic [2:0] op, input logic [7:0] ch,
                                input logic [7:0] attr, input logic [7:0] col,
                                input logic [7:0] row, input bit no_gap);
        int gap;
        s_tdata  <= {row, col, attr, ch};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(op, ch, attr, col, row);
        words_sent++;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_default_attr(input logic [7:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_blank_attr(value);
    endtask

    // A run of characters, often from a fresh cursor near the bottom so that scrolls happen.
    task automatic text_burst();
        int  len;
        bit  calm;
        logic [7:0] ch;
        calm = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1))
            send_command(OP_SET_CURSOR, rnd8(), rnd8(),
                         ($urandom_range(0, 9) < 3) ? 8'($urandom_range(60, 79))
                                                    : 8'($urandom_range(0, 79)),
                         ($urandom_range(0, 9) < 4) ? 8'($urandom_range(22, 24))
                                                    : 8'($urandom_range(0, 24)),
                         calm);
        len = $urandom_range(3, 20);
        repeat (len)
        begin
            ch = ($urandom_range(0, 9) == 0) ? NEWLINE_CHAR : rnd8();
            send_command(OP_PUT_CHAR, ch, rnd8(), rnd8(), rnd8(), calm);
        end
    endtask

    task automatic random_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            text_burst();
        else if (r < 55)
            send_command(OP_NEWLINE, rnd8(), rnd8(), rnd8(), rnd8(), 1'b0);
        else if (r < 63)
            send_command(OP_SET_CURSOR, rnd8(), rnd8(), pick_coord(SCREEN_COLS),
                         pick_coord(SCREEN_ROWS), 1'b0);
        else if (r < 75)
            send_command(OP_READ_CELL, rnd8(), rnd8(), pick_coord(SCREEN_COLS),
                         pick_coord(SCREEN_ROWS), 1'b0);
        else if (r < 82)
            send_command(OP_CLEAR_ROW, rnd8(), rnd8(), rnd8(), pick_coord(SCREEN_ROWS), 1'b0);
        else if (r < 89)
            send_command(OP_CLEAR_EOL, rnd8(), rnd8(), rnd8(), rnd8(), 1'b0);
        else if (r < 93)
            send_command(OP_CLEAR_SCREEN, rnd8(), rnd8(), rnd8(), rnd8(), 1'b0);
        else if (r < 97)
            send_command(OP_SET_BG, rnd8(), rnd8(), rnd8(), rnd8(), 1'b0);
        else
            send_command(3'($urandom_range(0, 7)), rnd8(), rnd8(), rnd8(), rnd8(), 1'b0);
    endtask

    // Status word receiver with random back-pressure.
    initial
    begin
        int stall_left;
        int calm_left;
        int r;
        stall_left = 0;
        calm_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (long_hold_req)
            begin
                stall_left = LONG_HOLD;
                calm_left = 0;
                long_hold_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                m_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    m_tready <= 1'b1;
                else if (r < 85)
                begin
                    stall_left = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end
                else if (r < 93)
                begin
                    calm_left = $urandom_range(20, 80);
                    m_tready <= 1'b1;
                end
                else
                begin
                    stall_left = $urandom_range(15, 90);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] phase_attr;
        int         phase_end;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'h00;
        s_tvalid  <= 1'b0;
        s_tdata   <= 32'h0;
        s_tuser   <= OP_PUT_CHAR;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset attribute.
        send_command(OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0);
        send_command(OP_READ_CELL, 8'h00, 8'h00, 8'd127, 8'd127, 1'b0);
        send_command(OP_PUT_CHAR, 8'h41, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_command(OP_PUT_CHAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_command(OP_PUT_CHAR, NEWLINE_CHAR, 8'h1E, 8'h00, 8'h00, 1'b0);
        send_command(OP_NEWLINE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        // Filling the last cell leaves the cursor past the end without a scroll.
        send_command(OP_SET_CURSOR, 8'h00, 8'h00, 8'd79, 8'd24, 1'b0);
        send_command(OP_PUT_CHAR, 8'hFF, 8'h80, 8'h00, 8'h00, 1'b0);
        send_command(OP_CLEAR_EOL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_command(OP_NEWLINE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_command(OP_SET_CURSOR, 8'h00, 8'h00, 8'd79, 8'd24, 1'b1);
        send_command(OP_PUT_CHAR, 8'h7E, 8'h4C, 8'h00, 8'h00, 1'b1);
        send_command(OP_PUT_CHAR, 8'h80, 8'h01, 8'h00, 8'h00, 1'b1);
        send_command(OP_SET_CURSOR, 8'h00, 8'h00, 8'd127, 8'd127, 1'b0);
        send_command(OP_NEWLINE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_command(OP_SET_CURSOR, 8'h00, 8'h00, 8'h80, 8'h80, 1'b0);
        send_command(OP_CLEAR_ROW, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        send_command(OP_CLEAR_ROW, 8'h00, 8'h00, 8'h00, 8'd25, 1'b0);
        send_command(OP_CLEAR_ROW, 8'h00, 8'h00, 8'h00, 8'd127, 1'b0);
        send_command(OP_CLEAR_ROW, 8'h00, 8'h00, 8'h00, 8'd0, 1'b0);
        send_command(OP_SET_CURSOR, 8'h00, 8'h00, 8'd40, 8'd3, 1'b0);
        send_command(OP_CLEAR_EOL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_command(OP_SET_BG, 8'h00, 8'hA5, 8'h00, 8'h00, 1'b0);
        send_command(OP_READ_CELL, 8'h00, 8'h00, 8'd40, 8'd3, 1'b0);
        send_command(OP_CLEAR_SCREEN, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_command(OP_READ_CELL, 8'h00, 8'h00, 8'd79, 8'd24, 1'b0);

        // Random phases, each under its own blank attribute, extremes first.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: phase_attr = 8'hFF;
                1: phase_attr = 8'h00;
                default: phase_attr = rnd8();
            endcase
            write_default_attr(phase_attr);
            // The receiver goes quiet while commands keep coming, so the input backs up.
            if (phase == 1 || phase == 3)
                long_hold_req = 1'b1;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
                random_command();
        end

        drain();
        if (sb.mismatch_count == 0 && sb.pending_count() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
hdl/tmcw_pkg.sv
hdl/tmcw_ram.sv
hdl/tmcw_dp.sv
hdl/tmcw_ctrl.sv
hdl/text_mode_console_writer_top.sv
verif/text_mode_console_writer_top_tb.sv
